[hdl/thsd_pkg.sv]
// shared types, constants and helpers of the two wheel hall sync drive
package thsd_pkg;

   localparam int TIME_BITS = 32;
   localparam int DIV_STEPS = TIME_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int OP_W      = 4;
   localparam int MODE_W    = 3;
   localparam int SPEED_W   = 16;
   localparam int WIDE_W    = 18;
   localparam int CFG_W     = 14;
   localparam int STEP_W    = 20;
   localparam int TURN_W    = 8;
   localparam int MAXW_W    = 15;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 20;

   localparam logic [CFG_W-1:0]  DRIVE_SPEED_RST = 14'd500;
   localparam logic [CFG_W-1:0]  ALIGN_SPEED_RST = 14'd250;
   localparam logic [CFG_W-1:0]  MAX_CORR_RST    = 14'd125;
   localparam logic [STEP_W-1:0] STEP_US_RST     = 20'd100;
   localparam logic [TURN_W-1:0] TURN_TARGET_RST = 8'd3;
   localparam logic [MAXW_W-1:0] MAX_WALK_RST    = 15'd1500;

   typedef enum logic [OP_W-1:0] {
      OP_HALL      = 4'd0,
      OP_STOP      = 4'd1,
      OP_ALIGN     = 4'd2,
      OP_FORWARD   = 4'd3,
      OP_BACKWARD  = 4'd4,
      OP_TURNLEFT  = 4'd5,
      OP_TURNRIGHT = 4'd6,
      OP_MANLEFT   = 4'd7,
      OP_MANRIGHT  = 4'd8
   } op_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_STOP   = 3'd0,
      MODE_MANUAL = 3'd1,
      MODE_ALIGN  = 3'd2,
      MODE_FWD    = 3'd3,
      MODE_BACK   = 3'd4,
      MODE_TLEFT  = 3'd5,
      MODE_TRIGHT = 3'd6
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DRIVE_SPEED = 3'd0,
      CSR_ALIGN_SPEED = 3'd1,
      CSR_MAX_CORR    = 3'd2,
      CSR_STEP_US     = 3'd3,
      CSR_TURN_TARGET = 3'd4,
      CSR_MAX_WALK    = 3'd5
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_CLAMP,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic ready;
      logic prep;
      logic step;
      logic clamp;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic sync_needed;
      logic div_last;
      logic out_free;
   } ctl_sts_type;

   function automatic logic [SPEED_W-1:0] sat_speed(input logic signed [WIDE_W-1:0] v,
                                                    input logic [MAXW_W-1:0] m);
      logic signed [WIDE_W-1:0] lim;
      logic signed [WIDE_W-1:0] r;
      lim = signed'({3'b000, m});
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end else begin
         r = v;
      end
      return r[SPEED_W-1:0];
   endfunction

endpackage

[hdl/thsd_req_if.sv]
// command and hall word channel
interface thsd_req_if import thsd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     opcode;
   logic                left_hall;
   logic [31:0]         left_time_us;
   logic                right_hall;
   logic [31:0]         right_time_us;
   logic signed [15:0]  manual_speed;

   modport source (output valid, opcode, left_hall, left_time_us, right_hall,
                   right_time_us, manual_speed, input ready);
   modport sink (input valid, opcode, left_hall, left_time_us, right_hall,
                 right_time_us, manual_speed, output ready);
endinterface

[hdl/thsd_rsp_if.sv]
// wheel speed result word channel
interface thsd_rsp_if import thsd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      left_write;
   logic signed [SPEED_W-1:0] left_speed;
   logic                      right_write;
   logic signed [SPEED_W-1:0] right_speed;
   logic                      aligned_pulse;
   logic                      turn_done_pulse;
   logic [MODE_W-1:0]         mode;

   modport source (output valid, left_write, left_speed, right_write, right_speed,
                   aligned_pulse, turn_done_pulse, mode, input ready);
   modport sink (input valid, left_write, left_speed, right_write, right_speed,
                 aligned_pulse, turn_done_pulse, mode, output ready);
endinterface

[hdl/thsd_csr_if.sv]
// configuration register write channel
interface thsd_csr_if import thsd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hdl/thsd_datapath.sv]
// drive state, serial divider, speed math and result register
module thsd_datapath import thsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   thsd_req_if.sink    req,
   thsd_rsp_if.source  rsp,
   thsd_csr_if.sink    csr,
   input  ctl_cmd_type cmd,
   output ctl_sts_type sts
);

   // configuration
   logic [CFG_W-1:0]  drive_speed_ff;
   logic [CFG_W-1:0]  align_speed_ff;
   logic [CFG_W-1:0]  max_corr_ff;
   logic [STEP_W-1:0] step_us_ff;
   logic [TURN_W-1:0] turn_target_ff;
   logic [MAXW_W-1:0] max_walk_ff;

   // drive state
   mode_type           mode_ff, mode_in;
   logic [TIME_BITS-1:0] left_stamp_ff, left_stamp_in;
   logic [TIME_BITS-1:0] right_stamp_ff, right_stamp_in;
   logic               left_fresh_ff, left_fresh_in;
   logic               right_fresh_ff, right_fresh_in;
   logic               left_done_ff, left_done_in;
   logic               right_done_ff, right_done_in;
   logic [TURN_W-1:0]  left_count_ff, left_count_in;
   logic [TURN_W-1:0]  right_count_ff, right_count_in;

   // divider
   logic [TIME_BITS-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]    divisor_ff, divisor_in;
   logic                 neg_ff, neg_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic signed [WIDE_W-1:0] corr_ff, corr_in;

   // result word
   logic               rsp_valid_ff;
   logic               lw_ff, lw_in;
   logic [SPEED_W-1:0] ls_ff, ls_in;
   logic               rw_ff, rw_in;
   logic [SPEED_W-1:0] rs_ff, rs_in;
   logic               aligned_ff, aligned_in;
   logic               turn_ff, turn_in;
   logic [MODE_W-1:0]  mode_out_ff, mode_out_in;

   logic take;
   logic load_imm;
   logic sync_needed;
   logic imm_lw, imm_rw, imm_al, imm_td;
   logic signed [WIDE_W-1:0] imm_ls, imm_rs;
   logic signed [WIDE_W-1:0] ds_wide, as_wide, man_wide;
   logic [TIME_BITS-1:0]     diff;
   logic [STEP_W:0]          rem_shift;
   logic [CFG_W-1:0]         mag;
   logic signed [WIDE_W-1:0] sync_l, sync_r;
   logic signed [WIDE_W-1:0] fin_ls, fin_rs;

   assign take     = req.valid && cmd.ready;
   assign load_imm = take && !sync_needed;
   assign req.ready = cmd.ready;
   assign csr.ready = 1'b1;

   assign ds_wide  = signed'({4'b0000, drive_speed_ff});
   assign as_wide  = signed'({4'b0000, align_speed_ff});
   assign man_wide = signed'({{2{req.manual_speed[15]}}, req.manual_speed});

   // item decode
   always_comb begin
      mode_in        = mode_ff;
      left_stamp_in  = left_stamp_ff;
      right_stamp_in = right_stamp_ff;
      left_fresh_in  = left_fresh_ff;
      right_fresh_in = right_fresh_ff;
      left_done_in   = left_done_ff;
      right_done_in  = right_done_ff;
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      sync_needed    = 1'b0;
      imm_lw = 1'b0;
      imm_rw = 1'b0;
      imm_al = 1'b0;
      imm_td = 1'b0;
      imm_ls = '0;
      imm_rs = '0;
      case (req.opcode)
         OP_HALL: begin
            if (mode_ff == MODE_ALIGN) begin
               if (req.left_hall && !left_done_ff) begin
                  imm_lw = 1'b1;
                  left_done_in = 1'b1;
               end
               if (req.right_hall && !right_done_ff) begin
                  imm_rw = 1'b1;
                  right_done_in = 1'b1;
               end
               if (left_done_in && right_done_in) begin
                  mode_in = MODE_STOP;
                  imm_al  = 1'b1;
               end
            end else if (mode_ff inside {MODE_TLEFT, MODE_TRIGHT}) begin
               if (req.left_hall && !left_done_ff) begin
                  left_count_in = left_count_ff + 8'd1;
                  if (left_count_in >= turn_target_ff) begin
                     imm_lw = 1'b1;
                     left_done_in = 1'b1;
                  end
               end
               if (req.right_hall && !right_done_ff) begin
                  right_count_in = right_count_ff + 8'd1;
                  if (right_count_in >= turn_target_ff) begin
                     imm_rw = 1'b1;
                     right_done_in = 1'b1;
                  end
               end
               if (left_done_in && right_done_in) begin
                  mode_in = MODE_STOP;
                  imm_td  = 1'b1;
               end
            end else if (mode_ff inside {MODE_FWD, MODE_BACK}) begin
               if (req.left_hall) begin
                  left_stamp_in = req.left_time_us;
                  left_fresh_in = 1'b1;
               end
               if (req.right_hall) begin
                  right_stamp_in = req.right_time_us;
                  right_fresh_in = 1'b1;
               end
               if (left_fresh_in && right_fresh_in) begin
                  sync_needed    = 1'b1;
                  left_fresh_in  = 1'b0;
                  right_fresh_in = 1'b0;
               end
            end
         end
         OP_STOP: begin
            mode_in = MODE_STOP;
            imm_lw  = 1'b1;
            imm_rw  = 1'b1;
         end
         OP_ALIGN: begin
            mode_in       = MODE_ALIGN;
            left_done_in  = 1'b0;
            right_done_in = 1'b0;
            imm_lw = 1'b1;
            imm_ls = as_wide;
            imm_rw = 1'b1;
            imm_rs = -as_wide;
         end
         OP_FORWARD: begin
            mode_in        = MODE_FWD;
            left_stamp_in  = '0;
            right_stamp_in = '0;
            left_fresh_in  = 1'b0;
            right_fresh_in = 1'b0;
            imm_lw = 1'b1;
            imm_ls = ds_wide;
            imm_rw = 1'b1;
            imm_rs = -ds_wide;
         end
         OP_BACKWARD: begin
            mode_in        = MODE_BACK;
            left_stamp_in  = '0;
            right_stamp_in = '0;
            left_fresh_in  = 1'b0;
            right_fresh_in = 1'b0;
            imm_lw = 1'b1;
            imm_ls = -ds_wide;
            imm_rw = 1'b1;
            imm_rs = ds_wide;
         end
         OP_TURNLEFT: begin
            mode_in        = MODE_TLEFT;
            left_count_in  = '0;
            right_count_in = '0;
            left_done_in   = 1'b0;
            right_done_in  = 1'b0;
            imm_lw = 1'b1;
            imm_ls = -ds_wide;
            imm_rw = 1'b1;
            imm_rs = -ds_wide;
         end
         OP_TURNRIGHT: begin
            mode_in        = MODE_TRIGHT;
            left_count_in  = '0;
            right_count_in = '0;
            left_done_in   = 1'b0;
            right_done_in  = 1'b0;
            imm_lw = 1'b1;
            imm_ls = ds_wide;
            imm_rw = 1'b1;
            imm_rs = ds_wide;
         end
         OP_MANLEFT: begin
            mode_in = MODE_MANUAL;
            imm_lw  = 1'b1;
            imm_ls  = man_wide;
         end
         OP_MANRIGHT: begin
            mode_in = MODE_MANUAL;
            imm_rw  = 1'b1;
            imm_rs  = man_wide;
         end
         default: begin
         end
      endcase
   end

   // divider and correction
   assign diff      = left_stamp_ff - right_stamp_ff;
   assign rem_shift = {rem_ff, quo_ff[TIME_BITS-1]};
   assign mag       = (quo_ff > TIME_BITS'(max_corr_ff)) ? max_corr_ff
                                                         : quo_ff[CFG_W-1:0];

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;
      cnt_in     = cnt_ff;
      corr_in    = corr_ff;
      if (cmd.prep) begin
         neg_in     = diff[TIME_BITS-1];
         quo_in     = diff[TIME_BITS-1] ? -diff : diff;
         rem_in     = '0;
         divisor_in = (step_us_ff == '0) ? STEP_W'(1) : step_us_ff;
         cnt_in     = '0;
      end else if (cmd.step) begin
         if (rem_shift >= {1'b0, divisor_ff}) begin
            rem_in = STEP_W'(rem_shift - {1'b0, divisor_ff});
            quo_in = {quo_ff[TIME_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[STEP_W-1:0];
            quo_in = {quo_ff[TIME_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.clamp) begin
         corr_in = neg_ff ? -signed'({4'b0000, mag}) : signed'({4'b0000, mag});
      end
   end

   assign sync_l = ds_wide + corr_ff;
   assign sync_r = ds_wide - corr_ff;
   assign fin_ls = (mode_ff == MODE_FWD) ? sync_l : -sync_l;
   assign fin_rs = (mode_ff == MODE_FWD) ? -sync_r : sync_r;

   // result word
   always_comb begin
      lw_in       = lw_ff;
      ls_in       = ls_ff;
      rw_in       = rw_ff;
      rs_in       = rs_ff;
      aligned_in  = aligned_ff;
      turn_in     = turn_ff;
      mode_out_in = mode_out_ff;
      if (cmd.finish) begin
         lw_in       = 1'b1;
         ls_in       = sat_speed(fin_ls, max_walk_ff);
         rw_in       = 1'b1;
         rs_in       = sat_speed(fin_rs, max_walk_ff);
         aligned_in  = 1'b0;
         turn_in     = 1'b0;
         mode_out_in = mode_ff;
      end else if (load_imm) begin
         lw_in       = imm_lw;
         ls_in       = sat_speed(imm_ls, max_walk_ff);
         rw_in       = imm_rw;
         rs_in       = sat_speed(imm_rs, max_walk_ff);
         aligned_in  = imm_al;
         turn_in     = imm_td;
         mode_out_in = mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_speed_ff <= DRIVE_SPEED_RST;
         align_speed_ff <= ALIGN_SPEED_RST;
         max_corr_ff    <= MAX_CORR_RST;
         step_us_ff     <= STEP_US_RST;
         turn_target_ff <= TURN_TARGET_RST;
         max_walk_ff    <= MAX_WALK_RST;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_DRIVE_SPEED: drive_speed_ff <= csr.data[CFG_W-1:0];
            CSR_ALIGN_SPEED: align_speed_ff <= csr.data[CFG_W-1:0];
            CSR_MAX_CORR:    max_corr_ff    <= csr.data[CFG_W-1:0];
            CSR_STEP_US:     step_us_ff     <= csr.data[STEP_W-1:0];
            CSR_TURN_TARGET: turn_target_ff <= csr.data[TURN_W-1:0];
            CSR_MAX_WALK:    max_walk_ff    <= csr.data[MAXW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_STOP;
         left_stamp_ff  <= '0;
         right_stamp_ff <= '0;
         left_fresh_ff  <= 1'b0;
         right_fresh_ff <= 1'b0;
         left_done_ff   <= 1'b0;
         right_done_ff  <= 1'b0;
         left_count_ff  <= '0;
         right_count_ff <= '0;
      end else if (take) begin
         mode_ff        <= mode_in;
         left_stamp_ff  <= left_stamp_in;
         right_stamp_ff <= right_stamp_in;
         left_fresh_ff  <= left_fresh_in;
         right_fresh_ff <= right_fresh_in;
         left_done_ff   <= left_done_in;
         right_done_ff  <= right_done_in;
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
      corr_ff    <= corr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_imm || cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      lw_ff       <= lw_in;
      ls_ff       <= ls_in;
      rw_ff       <= rw_in;
      rs_ff       <= rs_in;
      aligned_ff  <= aligned_in;
      turn_ff     <= turn_in;
      mode_out_ff <= mode_out_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.left_write      = lw_ff;
   assign rsp.left_speed      = signed'(ls_ff);
   assign rsp.right_write     = rw_ff;
   assign rsp.right_speed     = signed'(rs_ff);
   assign rsp.aligned_pulse   = aligned_ff;
   assign rsp.turn_done_pulse = turn_ff;
   assign rsp.mode            = mode_out_ff;

   assign sts.req_valid   = req.valid;
   assign sts.sync_needed = sync_needed;
   assign sts.div_last    = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign sts.out_free    = !rsp_valid_ff || rsp.ready;

`ifndef ASSERT_OFF
   a_finish_writes_both: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff && lw_ff && rw_ff)
      else $error("sync word without both wheel writes");

   a_plain_item_result: assert property (@(posedge clock) disable iff (reset)
      load_imm |=> rsp_valid_ff)
      else $error("plain item gave no result word");

   a_left_speed_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ls_ff == sat_speed(signed'({{2{ls_ff[15]}}, ls_ff}), max_walk_ff))
      else $error("left speed beyond walk limit");
`endif

endmodule

[hdl/thsd_ctrl.sv]
// sequencing state machine for item intake and sync divide
module thsd_ctrl import thsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.ready = sts.out_free;
            if (sts.req_valid && sts.out_free && sts.sync_needed) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_sync_item_starts_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.ready && sts.req_valid && sts.sync_needed |=> state_ff == ST_PREP)
      else $error("sync item did not start the divide");

   a_divide_ends_in_clamp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && sts.div_last |=> state_ff == ST_CLAMP)
      else $error("divide did not end in clamp");

   a_clamp_then_finish: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLAMP |=> state_ff == ST_FIN)
      else $error("clamp not followed by finish");
`endif

endmodule

[hdl/two_wheel_hall_sync_drive.sv]
// top level of the two wheel hall sync drive
// plain commands and hall words: result word valid in the cycle after the word is taken,
//   one word per cycle while the result side keeps taking
// hall words that close a phase sync: prep, the 32 step restoring divider, clamp, then a finish
//   state that writes the result word once the result register is free; no new word is taken until idle
// synchronous active high reset: stop mode, state cleared, registers at their defaults
module two_wheel_hall_sync_drive import thsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   thsd_req_if.sink   req_ch,
   thsd_rsp_if.source rsp_ch,
   thsd_csr_if.sink   csr_ch
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   thsd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   thsd_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch),
      .cmd   (cmd),
      .sts   (sts)
   );

endmodule

[tb/thsd_drive_checker.sv]
// checker for the two wheel hall sync drive: predicts each result word and compares it
module thsd_drive_checker import thsd_pkg::*; (
   input  logic clock,
   input  logic reset,
   thsd_req_if  req_ch,
   thsd_rsp_if  rsp_ch,
   thsd_csr_if  csr_ch,
   output int   mismatches,
   output int   waiting_words,
   output int   words_checked,
   output int   sync_words,
   output int   align_words,
   output int   turn_words
);

   typedef struct packed {
      logic              left_write;
      logic [SPEED_W-1:0] left_speed;
      logic              right_write;
      logic [SPEED_W-1:0] right_speed;
      logic              aligned_pulse;
      logic              turn_done_pulse;
      logic [MODE_W-1:0] mode;
   } speed_word_type;

   speed_word_type pending_speeds[$];

   logic [CFG_W-1:0]  cfg_drive;
   logic [CFG_W-1:0]  cfg_align;
   logic [CFG_W-1:0]  cfg_max_corr;
   logic [STEP_W-1:0] cfg_step_us;
   logic [TURN_W-1:0] cfg_turn;
   logic [MAXW_W-1:0] cfg_max_walk;

   mode_type          cur_mode;
   logic [31:0]       left_stamp;
   logic [31:0]       right_stamp;
   logic              left_fresh;
   logic              right_fresh;
   logic              left_done;
   logic              right_done;
   logic [TURN_W-1:0] left_count;
   logic [TURN_W-1:0] right_count;

   function automatic logic [SPEED_W-1:0] clip_speed(input longint v);
      longint lim;
      lim = cfg_max_walk;
      if (v > lim) begin
         v = lim;
      end else if (v < -lim) begin
         v = -lim;
      end
      return v[SPEED_W-1:0];
   endfunction

   // wrapped stamp difference scaled and clamped
   function automatic longint phase_trim();
      logic [31:0]     diff;
      logic [31:0]     mag;
      longint unsigned divisor;
      longint unsigned quot;
      diff = left_stamp - right_stamp;
      mag = diff[31] ? (~diff + 32'd1) : diff;
      divisor = (cfg_step_us == '0) ? 1 : cfg_step_us;
      quot = mag / divisor;
      if (quot > cfg_max_corr) begin
         quot = cfg_max_corr;
      end
      return diff[31] ? -longint'(quot) : longint'(quot);
   endfunction

   function automatic speed_word_type predict_speeds(input logic [OP_W-1:0] op,
                                                     input logic lh, input logic [31:0] lt,
                                                     input logic rh, input logic [31:0] rt,
                                                     input logic [15:0] ms);
      speed_word_type w;
      longint      drv;
      longint      corr;
      w = '0;
      drv = cfg_drive;
      case (op)
         OP_HALL: begin
            if (cur_mode == MODE_ALIGN) begin
               if (lh && !left_done) begin
                  w.left_write = 1'b1;
                  w.left_speed = clip_speed(0);
                  left_done = 1'b1;
               end
               if (rh && !right_done) begin
                  w.right_write = 1'b1;
                  w.right_speed = clip_speed(0);
                  right_done = 1'b1;
               end
               if (left_done && right_done) begin
                  cur_mode = MODE_STOP;
                  w.aligned_pulse = 1'b1;
                  align_words++;
               end
            end else if (cur_mode == MODE_TLEFT || cur_mode == MODE_TRIGHT) begin
               if (lh && !left_done) begin
                  left_count = left_count + 1'b1;
                  if (left_count >= cfg_turn) begin
                     w.left_write = 1'b1;
                     w.left_speed = clip_speed(0);
                     left_done = 1'b1;
                  end
               end
               if (rh && !right_done) begin
                  right_count = right_count + 1'b1;
                  if (right_count >= cfg_turn) begin
                     w.right_write = 1'b1;
                     w.right_speed = clip_speed(0);
                     right_done = 1'b1;
                  end
               end
               if (left_done && right_done) begin
                  cur_mode = MODE_STOP;
                  w.turn_done_pulse = 1'b1;
                  turn_words++;
               end
            end else if (cur_mode == MODE_FWD || cur_mode == MODE_BACK) begin
               if (lh) begin
                  left_stamp = lt;
                  left_fresh = 1'b1;
               end
               if (rh) begin
                  right_stamp = rt;
                  right_fresh = 1'b1;
               end
               if (left_fresh && right_fresh) begin
                  corr = phase_trim();
                  w.left_write = 1'b1;
                  w.right_write = 1'b1;
                  if (cur_mode == MODE_FWD) begin
                     w.left_speed = clip_speed(drv + corr);
                     w.right_speed = clip_speed(-(drv - corr));
                  end else begin
                     w.left_speed = clip_speed(-(drv + corr));
                     w.right_speed = clip_speed(drv - corr);
                  end
                  left_fresh = 1'b0;
                  right_fresh = 1'b0;
                  sync_words++;
               end
            end
         end
         OP_STOP: begin
            cur_mode = MODE_STOP;
            w.left_write = 1'b1;
            w.left_speed = clip_speed(0);
            w.right_write = 1'b1;
            w.right_speed = clip_speed(0);
         end
         OP_ALIGN: begin
            cur_mode = MODE_ALIGN;
            left_done = 1'b0;
            right_done = 1'b0;
            w.left_write = 1'b1;
            w.left_speed = clip_speed(cfg_align);
            w.right_write = 1'b1;
            w.right_speed = clip_speed(-longint'(cfg_align));
         end
         OP_FORWARD, OP_BACKWARD: begin
            left_stamp = '0;
            right_stamp = '0;
            left_fresh = 1'b0;
            right_fresh = 1'b0;
            cur_mode = (op == OP_FORWARD) ? MODE_FWD : MODE_BACK;
            w.left_write = 1'b1;
            w.right_write = 1'b1;
            w.left_speed = clip_speed((op == OP_FORWARD) ? drv : -drv);
            w.right_speed = clip_speed((op == OP_FORWARD) ? -drv : drv);
         end
         OP_TURNLEFT, OP_TURNRIGHT: begin
            left_count = '0;
            right_count = '0;
            left_done = 1'b0;
            right_done = 1'b0;
            cur_mode = (op == OP_TURNLEFT) ? MODE_TLEFT : MODE_TRIGHT;
            w.left_write = 1'b1;
            w.right_write = 1'b1;
            w.left_speed = clip_speed((op == OP_TURNLEFT) ? -drv : drv);
            w.right_speed = clip_speed((op == OP_TURNLEFT) ? -drv : drv);
         end
         OP_MANLEFT: begin
            cur_mode = MODE_MANUAL;
            w.left_write = 1'b1;
            w.left_speed = clip_speed(longint'($signed(ms)));
         end
         OP_MANRIGHT: begin
            cur_mode = MODE_MANUAL;
            w.right_write = 1'b1;
            w.right_speed = clip_speed(longint'($signed(ms)));
         end
         default: begin
         end
      endcase
      w.mode = cur_mode;
      return w;
   endfunction

   task automatic check_field(input string name, input logic signed [16:0] want,
                              input logic signed [16:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      speed_word_type want;
      if (reset) begin
         cfg_drive = DRIVE_SPEED_RST;
         cfg_align = ALIGN_SPEED_RST;
         cfg_max_corr = MAX_CORR_RST;
         cfg_step_us = STEP_US_RST;
         cfg_turn = TURN_TARGET_RST;
         cfg_max_walk = MAX_WALK_RST;
         cur_mode = MODE_STOP;
         left_stamp = '0;
         right_stamp = '0;
         left_fresh = 1'b0;
         right_fresh = 1'b0;
         left_done = 1'b0;
         right_done = 1'b0;
         left_count = '0;
         right_count = '0;
         pending_speeds.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_DRIVE_SPEED: cfg_drive = csr_ch.data[CFG_W-1:0];
               CSR_ALIGN_SPEED: cfg_align = csr_ch.data[CFG_W-1:0];
               CSR_MAX_CORR:    cfg_max_corr = csr_ch.data[CFG_W-1:0];
               CSR_STEP_US:     cfg_step_us = csr_ch.data[STEP_W-1:0];
               CSR_TURN_TARGET: cfg_turn = csr_ch.data[TURN_W-1:0];
               CSR_MAX_WALK:    cfg_max_walk = csr_ch.data[MAXW_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_speeds.size() == 0) begin
               $error("result word with no command or hall word waiting");
               mismatches++;
            end else begin
               want = pending_speeds.pop_front();
               words_checked++;
               check_field("left_write", want.left_write, rsp_ch.left_write);
               check_field("left_speed", $signed(want.left_speed), rsp_ch.left_speed);
               check_field("right_write", want.right_write, rsp_ch.right_write);
               check_field("right_speed", $signed(want.right_speed), rsp_ch.right_speed);
               check_field("aligned_pulse", want.aligned_pulse, rsp_ch.aligned_pulse);
               check_field("turn_done_pulse", want.turn_done_pulse, rsp_ch.turn_done_pulse);
               check_field("mode", want.mode, rsp_ch.mode);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_speeds.push_back(predict_speeds(req_ch.opcode, req_ch.left_hall,
                                                    req_ch.left_time_us, req_ch.right_hall,
                                                    req_ch.right_time_us,
                                                    req_ch.manual_speed));
         end
      end
      waiting_words = pending_speeds.size();
   end

endmodule

[tb/tb_two_wheel_hall_sync_drive.sv]
// testbench top of the two wheel hall sync drive: stimulus, settings and verdict
module tb_two_wheel_hall_sync_drive;
   import thsd_pkg::*;

   localparam int PERIOD      = 20;
   localparam int LATENCY     = 40;
   localparam int LONG_HOLD   = 80;
   localparam int PHASES      = 8;
   localparam int PHASE_WORDS = 104;
   localparam int RUN_LIMIT   = 400000;

   localparam logic [OP_W-1:0]      OP_FIRST_UNUSED = 4'd9;
   localparam logic [OP_W-1:0]      OP_LAST_UNUSED  = 4'd15;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE       = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bit          calm;
   bit          long_hold;
   int          sent_words;
   int          settings_loaded;
   int          stamp_spread;
   logic [31:0] clock_us;

   int mismatches;
   int waiting_words;
   int words_checked;
   int sync_words;
   int align_words;
   int turn_words;

   thsd_req_if req_ch ();
   thsd_rsp_if rsp_ch ();
   thsd_csr_if csr_ch ();

   two_wheel_hall_sync_drive DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   thsd_drive_checker speed_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .mismatches    (mismatches),
      .waiting_words (waiting_words),
      .words_checked (words_checked),
      .sync_words    (sync_words),
      .align_words   (align_words),
      .turn_words    (turn_words)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic bit coin(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic logic [31:0] pick_stamp();
      case (stamp_spread)
         0: return clock_us + $urandom_range(0, 50);
         1: return clock_us + $urandom_range(0, 20000);
         2: return clock_us + $urandom_range(0, 3000000);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_word(input logic [OP_W-1:0] op, input logic lh, input logic [31:0] lt,
                            input logic rh, input logic [31:0] rt, input logic [15:0] ms,
                            input bit counted);
      if (!calm && coin(20)) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.left_hall <= lh;
      req_ch.left_time_us <= lt;
      req_ch.right_hall <= rh;
      req_ch.right_time_us <= rt;
      req_ch.manual_speed <= ms;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (counted) begin
         sent_words++;
      end
   endtask

   task automatic send_cmd(input logic [OP_W-1:0] op, input logic [15:0] ms);
      send_word(op, coin(50), $urandom(), coin(50), $urandom(), ms, 1'b1);
   endtask

   task automatic send_hall(input logic lh, input logic rh);
      clock_us += $urandom_range(1000, 100000);
      send_word(OP_HALL, lh, pick_stamp(), rh, pick_stamp(), $urandom(), 1'b1);
   endtask

   task automatic send_hall_at(input logic lh, input logic [31:0] lt,
                               input logic rh, input logic [31:0] rt);
      send_word(OP_HALL, lh, lt, rh, rt, $urandom(), 1'b1);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (waiting_words != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic load_setting(input int ph);
      logic [CSR_DAT_W-1:0] drv, aln, corr, stp, trn, walk;
      case (ph)
         0: begin
            drv = 16383;
            aln = 16383;
            corr = 16383;
            stp = 1000000;
            trn = 255;
            walk = 32767;
         end
         1: begin
            // zero divisor and zero turn target
            drv = 0;
            aln = 0;
            corr = 0;
            stp = 0;
            trn = 0;
            walk = 0;
         end
         default: begin
            drv = $urandom_range(0, 16383);
            aln = $urandom_range(0, 16383);
            corr = $urandom_range(0, 16383);
            stp = coin(70) ? $urandom_range(1, 300) : $urandom_range(1, 1000000);
            trn = coin(80) ? $urandom_range(1, 6) : $urandom_range(0, 255);
            walk = coin(50) ? $urandom_range(0, 32767) : $urandom_range(0, 3000);
         end
      endcase
      if (ph == 2) begin
         stp = 1;
         corr = 16383;
         walk = 32767;
         trn = 1;
      end
      write_reg(CSR_DRIVE_SPEED, drv);
      write_reg(CSR_ALIGN_SPEED, aln);
      write_reg(CSR_MAX_CORR, corr);
      write_reg(CSR_STEP_US, stp);
      write_reg(CSR_TURN_TARGET, trn);
      write_reg(CSR_MAX_WALK, walk);
      if (ph == 4) begin
         write_reg(CSR_SPARE, $urandom());
      end
      csr_ch.valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic run_scenario();
      int pick;
      int n;
      logic [15:0] ms;
      pick = $urandom_range(0, 99);
      stamp_spread = $urandom_range(0, 3);
      if (pick < 35) begin
         send_cmd(coin(50) ? OP_FORWARD : OP_BACKWARD, $urandom());
         n = $urandom_range(2, 10);
         repeat (n) begin
            if (coin(60)) begin
               send_hall(1'b1, 1'b1);
            end else if (coin(90)) begin
               send_hall(coin(50), coin(50));
            end else begin
               send_hall(1'b0, 1'b0);
            end
         end
      end else if (pick < 50) begin
         send_cmd(OP_ALIGN, $urandom());
         n = $urandom_range(1, 5);
         repeat (n) send_hall(coin(60), coin(60));
      end else if (pick < 70) begin
         send_cmd(coin(50) ? OP_TURNLEFT : OP_TURNRIGHT, $urandom());
         n = $urandom_range(1, 8);
         repeat (n) send_hall(coin(75), coin(75));
      end else if (pick < 82) begin
         ms = coin(50) ? 16'($urandom()) : 16'($urandom_range(0, 4000) - 2000);
         send_cmd(coin(50) ? OP_MANLEFT : OP_MANRIGHT, ms);
         if (coin(30)) begin
            send_hall(coin(50), coin(50));
         end
      end else if (pick < 88) begin
         send_cmd(OP_STOP, $urandom());
      end else if (coin(50)) begin
         send_word($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED), coin(50), $urandom(),
                   coin(50), $urandom(), $urandom(), 1'b0);
      end else begin
         send_word(OP_HALL, coin(50), $urandom(), coin(50), $urandom(), $urandom(), 1'b0);
      end
   endtask

   // result side: short random stalls, one long hold when asked
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold = 1'b0;
            rsp_ch.ready <= 1'b1;
         end else if (!calm && coin(17)) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      #(RUN_LIMIT * PERIOD);
      $error("run did not finish in time");
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int phase_start;
      req_ch.valid <= 1'b0;
      req_ch.opcode <= OP_HALL;
      req_ch.left_hall <= 1'b0;
      req_ch.left_time_us <= '0;
      req_ch.right_hall <= 1'b0;
      req_ch.right_time_us <= '0;
      req_ch.manual_speed <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_DRIVE_SPEED;
      csr_ch.data <= '0;
      clock_us = $urandom();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at reset settings
      send_hall_at(1'b1, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
      send_word(OP_FIRST_UNUSED, 1'b1, $urandom(), 1'b1, $urandom(), $urandom(), 1'b1);
      send_word(OP_LAST_UNUSED, 1'b0, $urandom(), 1'b0, $urandom(), $urandom(), 1'b1);
      send_cmd(OP_MANLEFT, 16'h7FFF);
      send_cmd(OP_MANRIGHT, 16'h8000);
      send_hall_at(1'b1, 32'h0, 1'b1, 32'h0);
      send_cmd(OP_ALIGN, $urandom());
      send_hall_at(1'b1, $urandom(), 1'b0, $urandom());
      send_hall_at(1'b1, $urandom(), 1'b0, $urandom());
      send_hall_at(1'b0, $urandom(), 1'b1, $urandom());
      send_cmd(OP_TURNLEFT, $urandom());
      repeat (3) send_hall_at(1'b1, $urandom(), 1'b1, $urandom());
      send_cmd(OP_TURNRIGHT, $urandom());
      repeat (3) send_hall_at(1'b1, $urandom(), 1'b1, $urandom());
      send_cmd(OP_FORWARD, $urandom());
      send_hall_at(1'b1, 32'h0000_1000, 1'b1, 32'hFFFF_F000);
      send_hall_at(1'b1, 32'h8000_0000, 1'b0, 32'hFFFF_FFFF);
      send_hall_at(1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000);
      send_cmd(OP_BACKWARD, $urandom());
      send_hall_at(1'b1, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF);
      send_cmd(OP_STOP, 16'hFFFF);

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         load_setting(ph);
         if (ph == PHASES - 1) begin
            calm = 1'b1;
         end
         if (ph == 3) begin
            long_hold = 1'b1;
         end
         phase_start = sent_words;
         while (sent_words - phase_start < PHASE_WORDS) run_scenario();
      end

      wait_idle();
      $display("checked %0d result words: %0d phase sync updates, %0d alignments, %0d turns",
               words_checked, sync_words, align_words, turn_words);
      $display("%0d register settings from minimum to maximum, one long result stall",
               settings_loaded);
      if (mismatches == 0 && waiting_words == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
